@@ src/cfpb_pkg.sv @@
// Shared types, constants and the CRC-16/ARC byte update for the frame builder.
package cfpb_pkg;

  // Framing bytes
  localparam logic [7:0] StxHi = 8'h02;
  localparam logic [7:0] StxLo = 8'h5B;
  localparam logic [7:0] EtxHi = 8'h5D;
  localparam logic [7:0] EtxLo = 8'h03;

  // Reflected CRC-16/ARC polynomial
  localparam logic [15:0] CrcPoly = 16'hA001;

  // Length field counts the command and subcommand bytes on top of the payload
  localparam logic [15:0] LenExtra = 16'd2;

  // Job queue between front and back
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic {
    OP_START   = 1'b0,
    OP_PAYLOAD = 1'b1
  } cfpb_op_e;

  // One job for the back part: either a whole header or one payload byte
  typedef struct packed {
    logic        is_start;
    logic        close;     // append CRC and ETX after this job's bytes
    logic [7:0]  seq;
    logic [15:0] flen;
    logic [7:0]  cmd;
    logic [7:0]  sub_cmd;
    logic [7:0]  data;
  } cfpb_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cfpb_qstat_t;

  function automatic logic [15:0] crc_arc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ src/cfpb_front.sv @@
// Front part: accept input beats, track frame state and queue jobs for the back part.
module cfpb_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   op_i,
  input  logic [7:0]             cmd_i,
  input  logic [7:0]             sub_cmd_i,
  input  logic [15:0]            payload_len_i,
  input  logic [7:0]             data_byte_i,
  input  cfpb_pkg::cfpb_qstat_t  qstat_i,
  output logic                   push_o,
  output cfpb_pkg::cfpb_job_t    job_o
);
  import cfpb_pkg::*;

  logic [7:0]  seq_q, seq_d;
  logic [15:0] bytes_left_q, bytes_left_d;
  logic        in_frame_q, in_frame_d;
  logic        accept;
  logic        is_start;

  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i && !qstat_i.full;
  assign is_start   = (cfpb_op_e'(op_i) == OP_START);

  always_comb begin
    seq_d        = seq_q;
    bytes_left_d = bytes_left_q;
    in_frame_d   = in_frame_q;
    push_o       = 1'b0;

    job_o.is_start = is_start;
    job_o.seq      = seq_q;
    job_o.flen     = payload_len_i + LenExtra;
    job_o.cmd      = cmd_i;
    job_o.sub_cmd  = sub_cmd_i;
    job_o.data     = data_byte_i;
    job_o.close    = is_start ? (payload_len_i == 16'd0) : (bytes_left_q == 16'd1);

    if (accept) begin
      if (is_start) begin
        // a start abandons any open frame
        push_o       = 1'b1;
        seq_d        = seq_q + 8'd1;
        bytes_left_d = payload_len_i;
        in_frame_d   = (payload_len_i != 16'd0);
      end else if (in_frame_q) begin
        push_o       = 1'b1;
        bytes_left_d = bytes_left_q - 16'd1;
        in_frame_d   = (bytes_left_q != 16'd1);
      end
      // otherwise drop the stray payload byte
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q        <= '0;
      bytes_left_q <= '0;
      in_frame_q   <= 1'b0;
    end else begin
      seq_q        <= seq_d;
      bytes_left_q <= bytes_left_d;
      in_frame_q   <= in_frame_d;
    end
  end

endmodule

@@ src/cfpb_queue.sv @@
// Short job queue between front and back parts.
module cfpb_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  cfpb_pkg::cfpb_job_t    job_i,
  input  logic                   pop_i,
  output cfpb_pkg::cfpb_job_t    job_o,
  output cfpb_pkg::cfpb_qstat_t  qstat_o
);
  import cfpb_pkg::*;

  cfpb_job_t              mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]   count_q, count_d;

  assign qstat_o.full  = (count_q == QueueCntW'(QueueDepth));
  assign qstat_o.empty = (count_q == '0);
  assign job_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

@@ src/cfpb_back.sv @@
// Back part: serialise queued jobs into frame bytes, run the CRC, hold the output register.
module cfpb_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfpb_pkg::cfpb_job_t    job_i,
  input  cfpb_pkg::cfpb_qstat_t  qstat_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             tx_byte_o,
  output logic                   frame_last_o
);
  import cfpb_pkg::*;

  typedef enum logic [12:0] {
    PH_HEAD = 13'd1,
    PH_STX0 = 13'd2,
    PH_STX1 = 13'd4,
    PH_SEQ  = 13'd8,
    PH_LENH = 13'd16,
    PH_LENL = 13'd32,
    PH_CMD  = 13'd64,
    PH_SUB  = 13'd128,
    PH_DATA = 13'd256,
    PH_CRCH = 13'd512,
    PH_CRCL = 13'd1024,
    PH_ETX0 = 13'd2048,
    PH_ETX1 = 13'd4096
  } cfpb_phase_e;

  cfpb_phase_e phase_q, phase_d, phase_eff, phase_next;
  logic [15:0] crc_q, crc_d;
  logic        out_valid_q;
  logic [7:0]  tx_byte_q;
  logic        frame_last_q;
  logic [7:0]  byte_sel;
  logic        job_done;
  logic        advance;

  assign advance = !qstat_i.empty && (!out_valid_q || !out_stall_i);

  always_comb begin
    if (phase_q == PH_HEAD) begin
      phase_eff = job_i.is_start ? PH_STX0 : PH_DATA;
    end else begin
      phase_eff = phase_q;
    end
  end

  // byte, CRC update and successor phase for the current position
  always_comb begin
    byte_sel   = StxHi;
    crc_d      = crc_q;
    phase_next = PH_HEAD;
    job_done   = 1'b0;
    case (phase_eff)
      PH_STX0: begin
        byte_sel   = StxHi;
        phase_next = PH_STX1;
      end
      PH_STX1: begin
        byte_sel   = StxLo;
        phase_next = PH_SEQ;
      end
      PH_SEQ: begin
        byte_sel   = job_i.seq;
        crc_d      = crc_arc_byte(16'h0000, job_i.seq);
        phase_next = PH_LENH;
      end
      PH_LENH: begin
        byte_sel   = job_i.flen[15:8];
        crc_d      = crc_arc_byte(crc_q, job_i.flen[15:8]);
        phase_next = PH_LENL;
      end
      PH_LENL: begin
        byte_sel   = job_i.flen[7:0];
        crc_d      = crc_arc_byte(crc_q, job_i.flen[7:0]);
        phase_next = PH_CMD;
      end
      PH_CMD: begin
        byte_sel   = job_i.cmd;
        crc_d      = crc_arc_byte(crc_q, job_i.cmd);
        phase_next = PH_SUB;
      end
      PH_SUB: begin
        byte_sel   = job_i.sub_cmd;
        crc_d      = crc_arc_byte(crc_q, job_i.sub_cmd);
        phase_next = job_i.close ? PH_CRCH : PH_HEAD;
        job_done   = !job_i.close;
      end
      PH_DATA: begin
        byte_sel   = job_i.data;
        crc_d      = crc_arc_byte(crc_q, job_i.data);
        phase_next = job_i.close ? PH_CRCH : PH_HEAD;
        job_done   = !job_i.close;
      end
      PH_CRCH: begin
        byte_sel   = crc_q[15:8];
        phase_next = PH_CRCL;
      end
      PH_CRCL: begin
        byte_sel   = crc_q[7:0];
        phase_next = PH_ETX0;
      end
      PH_ETX0: begin
        byte_sel   = EtxHi;
        phase_next = PH_ETX1;
      end
      PH_ETX1: begin
        byte_sel   = EtxLo;
        phase_next = PH_HEAD;
        job_done   = 1'b1;
      end
      default: begin
        byte_sel   = StxHi;
        phase_next = PH_HEAD;
      end
    endcase
  end

  assign pop_o   = advance && job_done;
  assign phase_d = advance ? phase_next : phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEAD;
      crc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (advance) begin
        crc_q       <= crc_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      tx_byte_q    <= byte_sel;
      frame_last_q <= (phase_eff == PH_ETX1);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign tx_byte_o    = tx_byte_q;
  assign frame_last_o = frame_last_q;

endmodule

@@ src/crc_framed_packet_builder_core.sv @@
// Top level of the STX/ETX frame builder with CRC-16/ARC.
//
// Input channel (in_valid_i / in_stall_o): one beat is either a start item
// (op_i = 0, with cmd_i, sub_cmd_i, payload_len_i) or a payload byte
// (op_i = 1, data_byte_i). Output channel (out_valid_o / out_stall_i): one
// beat is one frame byte on tx_byte_o; frame_last_o marks the closing ETX byte.
// A beat moves on an edge with valid high and stall low on that channel.
//
// With nothing queued, an accepted beat is written into the job queue on the
// accepting edge, and its first byte is then loaded into the output register.
// Payload beats are accepted one per cycle while the job queue is not full,
// and the back part emits one byte per cycle while the receiver does not stall.
// A start beat becomes STX, sequence, length, command and subcommand bytes
// (plus CRC and ETX at length zero); a closing payload beat adds CRC and ETX.
// A four-entry job queue absorbs these bursts; in_stall_o rises only when that
// queue is full. Stray payload beats outside a frame are taken and dropped.
// Reset clears the sequence id, frame state, queue and output register.
// While the receiver stalls, the output beat holds and the queue fills.
module crc_framed_packet_builder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [7:0]  cmd_i,
  input  logic [7:0]  sub_cmd_i,
  input  logic [15:0] payload_len_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  tx_byte_o,
  output logic        frame_last_o
);
  import cfpb_pkg::*;

  cfpb_job_t   push_job;
  cfpb_job_t   head_job;
  cfpb_qstat_t qstat;
  logic        push;
  logic        pop;

  // Front: classify beats, keep sequence id and remaining payload count
  cfpb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .cmd_i         (cmd_i),
    .sub_cmd_i     (sub_cmd_i),
    .payload_len_i (payload_len_i),
    .data_byte_i   (data_byte_i),
    .qstat_i       (qstat),
    .push_o        (push),
    .job_o         (push_job)
  );

  // Queue: decouple acceptance from byte emission
  cfpb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .qstat_o (qstat)
  );

  // Back: expand each job into bytes and run the CRC
  cfpb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (head_job),
    .qstat_i      (qstat),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .tx_byte_o    (tx_byte_o),
    .frame_last_o (frame_last_o)
  );

endmodule

@@ src/cfpb_checker.sv @@
// Port-level checks for the frame builder, bound to the top level.
module cfpb_port_checks (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] tx_byte_o,
  input logic       frame_last_o
);
  import cfpb_pkg::*;

  // Hold a stalled output beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(tx_byte_o) && $stable(frame_last_o))
    else $error("stalled output beat changed");

  // Mark only the closing ETX byte as last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |-> tx_byte_o == EtxLo)
    else $error("frame_last on a byte other than ETX");

  // After a closed frame the next byte can only open a new frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && frame_last_o |=> !out_valid_o || tx_byte_o == StxHi)
    else $error("byte after frame end is not STX");

  // A valid output beat carries known bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown({tx_byte_o, frame_last_o}))
    else $error("unknown bits on a valid output beat");

endmodule

bind crc_framed_packet_builder_core cfpb_port_checks u_cfpb_port_checks (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .tx_byte_o    (tx_byte_o),
  .frame_last_o (frame_last_o)
);
